// ----- hw/rtl/trsp_pkg.sv -----
package trsp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned NUM_SLOTS = 12;
    localparam int unsigned IDX_W     = 4;
    localparam int unsigned KEEP_SLOT = 4;
    localparam int unsigned PEND_W    = 7;

    localparam int unsigned HEADER_BYTES_DEF = 4;
    localparam int unsigned LONG_SKIP_DEF    = 6;

    localparam logic [BYTE_W-1:0] TAG_END  = 8'h00;
    localparam logic [BYTE_W-1:0] TAG_LONG = 8'hFF;

    typedef logic [NUM_SLOTS-1:0][BYTE_W-1:0] slot_vec_t;

    // Slot 11 first, slot 0 last
    localparam slot_vec_t SLOT_DEFAULT = {
        8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF,
        8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF
    };

    typedef struct packed {
        logic      would_dump;
        logic      load;
        slot_vec_t slots;
    } dump_req_t;

endpackage

// ----- hw/rtl/trsp_parser.sv -----
module trsp_parser #(
    parameter int unsigned HEADER_BYTES = trsp_pkg::HEADER_BYTES_DEF,
    parameter int unsigned LONG_SKIP    = trsp_pkg::LONG_SKIP_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_fire,
    input  logic [trsp_pkg::BYTE_W-1:0] data_byte,
    input  logic                        record_start,
    output trsp_pkg::dump_req_t         dump_req
);
    import trsp_pkg::*;

    localparam int unsigned HdrW  = (HEADER_BYTES > 0) ? $clog2(HEADER_BYTES + 1) : 1;
    localparam int unsigned SkipW = $clog2(LONG_SKIP + 1);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_TAG    = 3'd2;
    localparam logic [2:0] PH_SKIP   = 3'd3;
    localparam logic [2:0] PH_VALUE  = 3'd4;

    logic [2:0]        phase_reg, phase_next, eff_phase;
    logic [HdrW-1:0]   hdr_reg, hdr_next, eff_hdr, hdr_dec;
    logic [SkipW-1:0]  skip_reg, skip_next, eff_skip, skip_dec;
    logic [PEND_W-1:0] pend_reg, pend_next, eff_pend;
    slot_vec_t         slots_reg, slots_next, eff_slots;
    logic              dump;

    always_comb
    begin
        eff_phase = phase_reg;
        eff_hdr   = hdr_reg;
        eff_skip  = skip_reg;
        eff_pend  = pend_reg;
        eff_slots = slots_reg;

        // A start drops whatever record was in progress
        if (record_start)
        begin
            for (int k = 0; k < NUM_SLOTS; k++)
            begin
                if (k != KEEP_SLOT)
                begin
                    eff_slots[k] = SLOT_DEFAULT[k];
                end
            end
            eff_skip = '0;
            eff_pend = '0;
            if (HEADER_BYTES == 0)
            begin
                eff_hdr   = '0;
                eff_phase = PH_TAG;
            end
            else
            begin
                eff_hdr   = HdrW'(HEADER_BYTES);
                eff_phase = PH_HEADER;
            end
        end

        hdr_dec  = (eff_hdr != '0) ? eff_hdr - HdrW'(1) : '0;
        skip_dec = (eff_skip != '0) ? eff_skip - SkipW'(1) : '0;

        phase_next = eff_phase;
        hdr_next   = eff_hdr;
        skip_next  = eff_skip;
        pend_next  = eff_pend;
        slots_next = eff_slots;
        dump       = 1'b0;

        case (eff_phase)
            PH_HEADER:
            begin
                hdr_next = hdr_dec;
                if (hdr_dec == '0)
                begin
                    phase_next = PH_TAG;
                end
            end
            PH_TAG:
            begin
                if (data_byte == TAG_END)
                begin
                    phase_next = PH_IDLE;
                    dump       = 1'b1;
                end
                else if (data_byte == TAG_LONG)
                begin
                    skip_next  = SkipW'(LONG_SKIP);
                    phase_next = PH_SKIP;
                end
                else if (!data_byte[BYTE_W-1])
                begin
                    skip_next  = SkipW'(1);
                    phase_next = PH_SKIP;
                end
                else
                begin
                    pend_next  = data_byte[PEND_W-1:0];
                    phase_next = PH_VALUE;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    phase_next = PH_TAG;
                end
            end
            PH_VALUE:
            begin
                // Tags past the last slot consume the value and drop it
                if (eff_pend < PEND_W'(NUM_SLOTS))
                begin
                    slots_next[eff_pend[IDX_W-1:0]] = data_byte;
                end
                phase_next = PH_TAG;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            hdr_reg   <= '0;
            skip_reg  <= '0;
            pend_reg  <= '0;
            slots_reg <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            hdr_reg   <= hdr_next;
            skip_reg  <= skip_next;
            pend_reg  <= pend_next;
            slots_reg <= slots_next;
        end
    end

    assign dump_req.would_dump = dump;
    assign dump_req.load       = in_fire && dump;
    assign dump_req.slots      = eff_slots;

endmodule

// ----- hw/rtl/trsp_dump.sv -----
module trsp_dump (
    input  logic                        clk,
    input  logic                        rst_n,
    input  trsp_pkg::dump_req_t         dump_req,
    input  logic                        out_stall,
    output logic                        out_valid,
    output logic [trsp_pkg::IDX_W-1:0]  slot_index,
    output logic [trsp_pkg::BYTE_W-1:0] slot_value,
    output logic                        last_slot,
    output logic                        freeing
);
    import trsp_pkg::*;

    logic            busy_reg, busy_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    slot_vec_t       buf_reg, buf_next;
    logic            beat;

    assign beat    = busy_reg && !out_stall;
    assign freeing = beat && last_slot;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        buf_next  = buf_reg;
        if (dump_req.load)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            buf_next  = dump_req.slots;
        end
        else if (beat)
        begin
            // Advance to the next slot; drop out of busy after the last one
            if (last_slot)
            begin
                busy_next = 1'b0;
            end
            cnt_next = cnt_reg + IDX_W'(1);
            buf_next = buf_reg >> BYTE_W;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    assign out_valid  = busy_reg;
    assign slot_index = cnt_reg;
    assign slot_value = buf_reg[0];
    assign last_slot  = (cnt_reg == IDX_W'(NUM_SLOTS - 1));

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        dump_req.load |-> (!busy_reg || freeing))
        else $error("dump loaded over a dump still in flight");

    a_dump_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (beat && !last_slot) |=> (out_valid && slot_index == $past(slot_index) + IDX_W'(1)))
        else $error("dump stopped before the last slot");

    a_dump_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (freeing && !dump_req.load) |=> !out_valid)
        else $error("dump ran past the last slot");
`endif

endmodule

// ----- hw/rtl/tagged_record_settings_parser_unit.sv -----
// Tagged record settings parser: one record byte per input beat.
// Input: one byte accepted per cycle; a byte ending a record is held off while an
//   earlier dump is still in flight, unless its last slot beat is taken that cycle.
// Output: the dump starts in the cycle after the end tag is accepted and delivers
//   twelve slot beats, one per cycle while out_stall is low, through the dump shift register.
// Reset: parser idle, all setting slots zero, no dump in flight.
module tagged_record_settings_parser_unit #(
    parameter int unsigned HEADER_BYTES = trsp_pkg::HEADER_BYTES_DEF,
    parameter int unsigned LONG_SKIP    = trsp_pkg::LONG_SKIP_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [trsp_pkg::BYTE_W-1:0] data_byte,
    input  logic                        record_start,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [trsp_pkg::IDX_W-1:0]  slot_index,
    output logic [trsp_pkg::BYTE_W-1:0] slot_value,
    output logic                        last_slot
);
    import trsp_pkg::*;

    dump_req_t dump_req;
    logic      in_fire;
    logic      freeing;

    // Hold off only a byte that would start a new dump while the dump register
    // is still busy and is not handing over its last beat in this cycle.
    assign in_stall = dump_req.would_dump && out_valid && !freeing;
    assign in_fire  = in_valid && !in_stall;

    // Parse state and the twelve setting slots; a dump request carries a
    // snapshot of the slots as they stand at the end tag.
    trsp_parser #(
        .HEADER_BYTES (HEADER_BYTES),
        .LONG_SKIP    (LONG_SKIP)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .data_byte    (data_byte),
        .record_start (record_start),
        .dump_req     (dump_req)
    );

    // Result register: shift the snapshot out one slot per beat.
    trsp_dump u_dump (
        .clk        (clk),
        .rst_n      (rst_n),
        .dump_req   (dump_req),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .slot_index (slot_index),
        .slot_value (slot_value),
        .last_slot  (last_slot),
        .freeing    (freeing)
    );

`ifndef SYNTHESIS
    a_stall_only_on_dump: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (dump_req.would_dump && out_valid))
        else $error("input held off without a dump clash");

    a_dump_follows_end: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && dump_req.would_dump) |=> (out_valid && slot_index == '0))
        else $error("end tag accepted but no dump started");

    a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_slot) |-> (slot_index == IDX_W'(NUM_SLOTS - 1)))
        else $error("last slot flag on wrong index");
`endif

endmodule
